### hw/rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap priority queue package
// Shared types, codes and default sizes for the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  // Default sizes.
  localparam int CAPACITY_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 8;
  localparam int STAT_W       = 2;

  // Operation codes carried in the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Status codes returned with every result.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

  // One input beat.
  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       entry_count;
    logic [STAT_W-1:0]        status;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_FILL,
    ST_RESP
  } hpq_state_t;

endpackage

### hw/rtl/hpq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/max_heap_priority_queue.sv
// Sequence: overflow and underflow go straight to the result; an insert reads one parent
// per level climbed (ST_UP_CMP); a remove moves the last entry to the root (ST_DN_LOAD), then
// reads the left and right child per level descended (ST_DN_RIGHT, ST_DN_CMP).
// One item at a time: the next is accepted at the edge that takes the result;
// each sift level waits on the registered RAM read. The receiver cannot stall the result.
// Reset (synchronous, rst_n low) empties the heap; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of signed values held in one RAM, with insert and
// remove-maximum operations; every operation returns the maximum, the entry
// count and a status.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hpq_pkg::in_item_t in_data,
  output logic              out_valid,
  output hpq_pkg::out_item_t out_data
);

  import hpq_pkg::*;

  // Index widths: CW holds 0..CAPACITY, IW holds child indexes beyond it.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = CW + 2;
  localparam logic [IW-1:0] IDX_ONE = IW'(1);
  localparam logic [CW-1:0] CAP     = CW'(CAPACITY);

  hpq_state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] lv_r, lv_nxt;
  logic                     has_right_r, has_right_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [DATA_W-1:0] top_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  // RAM port signals.
  logic [IW-1:0]     rd_idx, wr_idx;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;
  logic [IW-1:0]     rd_addr_full, wr_addr_full;

  // Shared decode.
  logic                     accept;
  logic                     is_insert;
  logic                     full;
  logic                     empty;
  logic [IW-1:0]            count_ext;
  logic [IW-1:0]            pos_ext;
  logic [IW-1:0]            parent_idx;
  logic                     up_swap;
  logic                     parent_root;
  logic [IW-1:0]            right_idx;
  logic                     take_right;
  logic signed [DATA_W-1:0] big_val;
  logic [IW-1:0]            big_idx;
  logic [IW-1:0]            big_left;
  logic                     dn_swap;
  logic                     big_has_kid;
  logic [CW+7:0]            count_wide;

  assign accept      = start && !busy;
  assign is_insert   = (in_data.action == ACT_INSERT);
  assign full        = (count_r == CAP);
  assign empty       = (count_r == '0);
  assign count_ext   = IW'(count_r);
  assign pos_ext     = IW'(pos_r);

  // Sift-up compare: the read data is the parent of the current hole.
  assign parent_idx  = pos_ext >> 1;
  assign up_swap     = $signed(rd_data) < val_r;
  assign parent_root = (parent_idx == IDX_ONE);

  // Sift-down compare: lv_r holds the left child, read data the right child.
  assign right_idx   = {pos_ext[IW-2:0], 1'b1};
  assign take_right  = has_right_r && (lv_r < $signed(rd_data));
  assign big_val     = take_right ? $signed(rd_data) : lv_r;
  assign big_idx     = {pos_ext[IW-2:0], take_right};
  assign big_left    = {big_idx[IW-2:0], 1'b0};
  assign dn_swap     = val_r < big_val;
  assign big_has_kid = (big_left <= count_ext);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (is_insert && full) begin
            state_nxt = ST_RESP;
          end else if (is_insert && empty) begin
            state_nxt = ST_FILL;
          end else if (is_insert) begin
            state_nxt = ST_UP_CMP;
          end else if (empty) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_DN_LOAD;
          end
        end
      end
      ST_UP_CMP: begin
        priority if (!up_swap) begin
          state_nxt = ST_RESP;
        end else if (parent_root) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end
      ST_DN_LOAD: begin
        priority if (empty) begin
          state_nxt = ST_RESP;
        end else if (count_r == CW'(1)) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_DN_RIGHT;
        end
      end
      ST_DN_RIGHT: begin
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        priority if (!dn_swap) begin
          state_nxt = ST_RESP;
        end else if (big_has_kid) begin
          state_nxt = ST_DN_RIGHT;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM accesses and result beat.
  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    lv_nxt        = lv_r;
    has_right_nxt = has_right_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_idx        = IDX_ONE;
    wr_en         = 1'b0;
    wr_idx        = pos_ext;
    wr_data       = val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = STAT_OK;
          priority if (is_insert && full) begin
            status_nxt = STAT_OVERFLOW;
          end else if (is_insert) begin
            // Open a hole after the last entry and fetch its parent.
            count_nxt = count_r + CW'(1);
            pos_nxt   = count_r + CW'(1);
            val_nxt   = in_data.value;
            rd_idx    = (count_ext + IDX_ONE) >> 1;
          end else if (empty) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            // Fetch the last entry; it moves to the root.
            count_nxt = count_r - CW'(1);
            rd_idx    = count_ext;
          end
        end
      end
      ST_UP_CMP: begin
        if (up_swap) begin
          // Parent moves down into the hole; fetch the next parent.
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = parent_idx[CW-1:0];
          rd_idx  = parent_idx >> 1;
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_DN_LOAD: begin
        // The hole starts at the root; fetch its left child.
        val_nxt = $signed(rd_data);
        pos_nxt = CW'(1);
        rd_idx  = IW'(2);
      end
      ST_DN_RIGHT: begin
        // Left child arrives; fetch the right child if it exists.
        lv_nxt        = $signed(rd_data);
        has_right_nxt = (right_idx <= count_ext);
        rd_idx        = right_idx;
      end
      ST_DN_CMP: begin
        if (dn_swap) begin
          // Larger child moves up into the hole; fetch its left child.
          wr_en   = 1'b1;
          wr_data = big_val;
          pos_nxt = big_idx[CW-1:0];
          rd_idx  = big_left;
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_FILL: begin
        wr_en = 1'b1;
      end
      ST_RESP: begin
        out_valid_nxt       = 1'b1;
        out_nxt.top_value   = empty ? '0 : top_r;
        out_nxt.entry_count = count_wide[COUNT_W-1:0];
        out_nxt.status      = status_r;
      end
      default: begin
      end
    endcase
  end

  assign count_wide   = (CW + 8)'(count_r);
  assign rd_addr_full = rd_idx - IDX_ONE;
  assign wr_addr_full = wr_idx - IDX_ONE;

  // Heap store, entries 1 to CAPACITY at addresses 0 to CAPACITY-1.
  hpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr_full[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers; the root copy follows every write to entry 1.
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    lv_r        <= lv_nxt;
    has_right_r <= has_right_nxt;
    status_r    <= status_nxt;
    out_r       <= out_nxt;
    if (wr_en && (wr_idx == IDX_ONE)) begin
      top_r <= $signed(wr_data);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives insert and remove-maximum commands into the heap queue and checks
// every reply against a behavioral copy of the heap. A short directed run
// covers the value extremes, the empty heap, duplicate keys and underflow.
// Random fill, drain and churn phases then take the heap to full (overflow)
// and back to empty (underflow), many times over.
// ----------------------------------------------------------------------------
module testbench;
  import hpq_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RAND_ITEMS     = 1950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // Traffic mix of one random phase.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_CHURN
  } mix_kind_t;

  // Shadow heap that predicts each reply and checks replies in order.
  class heap_scoreboard;
    logic signed [DATA_W-1:0] heap_vals [1:CAP];
    int                       held;
    out_item_t                expected_replies [$];
    int unsigned              fail_count;

    function new();
      held       = 0;
      fail_count = 0;
    endfunction

    function void swap_vals(int a, int b);
      logic signed [DATA_W-1:0] tmp;
      tmp          = heap_vals[a];
      heap_vals[a] = heap_vals[b];
      heap_vals[b] = tmp;
    endfunction

    // Apply one command to the shadow heap and return the reply it earns.
    function out_item_t apply_command(in_item_t cmd);
      out_item_t reply;
      int        pos;
      int        up;
      int        left;
      int        big;
      reply.status = STAT_OK;
      if (cmd.action == ACT_INSERT) begin
        if (held >= CAP) begin
          reply.status = STAT_OVERFLOW;
        end else begin
          held            = held + 1;
          heap_vals[held] = cmd.value;
          pos             = held;
          // Climb while the parent is strictly smaller.
          while (pos > 1) begin
            up = pos >> 1;
            if (!(heap_vals[up] < heap_vals[pos])) break;
            swap_vals(up, pos);
            pos = up;
          end
        end
      end else begin
        if (held == 0) begin
          reply.status = STAT_UNDERFLOW;
        end else begin
          heap_vals[1] = heap_vals[held];
          held         = held - 1;
          pos          = 1;
          // Descend toward the larger child; ties go left, a lone left child counts.
          forever begin
            left = pos * 2;
            if (left > held) break;
            big = left;
            if (left + 1 <= held && heap_vals[left] < heap_vals[left + 1]) big = left + 1;
            if (!(heap_vals[pos] < heap_vals[big])) break;
            swap_vals(pos, big);
            pos = big;
          end
        end
      end
      reply.top_value   = (held != 0) ? heap_vals[1] : '0;
      reply.entry_count = held[COUNT_W-1:0];
      return reply;
    endfunction

    // Note an accepted command beat.
    function void log_command(in_item_t cmd);
      expected_replies.push_back(apply_command(cmd));
    endfunction

    // Compare one reply beat with the oldest expectation.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none expected: top %0d count %0d status %0d",
                 $time, got.top_value, got.entry_count, got.status);
        fail_count++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.top_value !== want.top_value) begin
        $display("%0t: top_value expected %0d, got %0d", $time, want.top_value,
                 got.top_value);
        fail_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                 got.entry_count);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  heap_scoreboard sb = new();
  int             drv_held;
  int             quiet_cycles;

  max_heap_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: the reply of the previous command is checked before a new beat is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_reply(out_data);
      if (start && !busy) sb.log_command(in_data);
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired after %0d quiet cycles", $time, WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic in_item_t make_beat(logic act, logic signed [DATA_W-1:0] val);
    in_item_t beat;
    beat.action = act;
    beat.value  = val;
    return beat;
  endfunction

  // Mostly full-range values, with extremes and a narrow band that forces ties.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end else if (sel <= 3) begin
      return $signed($urandom_range(0, 8)) - 4;
    end
    return $urandom;
  endfunction

  // Offer one command beat, with an optional idle gap first, and wait for it to be taken.
  task automatic issue(in_item_t beat, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 24);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    if (beat.action == ACT_INSERT) begin
      if (drv_held < CAP) drv_held++;
    end else if (drv_held > 0) begin
      drv_held--;
    end
  endtask

  initial begin
    int        sent;
    int        steps;
    int        span;
    int        extra;
    int        ins_pct;
    int        pick;
    bit        may_idle;
    mix_kind_t kind;
    logic      act;

    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    drv_held = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty heap, value extremes, duplicates, drain to empty and past it.
    issue(make_beat(ACT_REMOVE, 32'sh12345678), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sh7fffffff), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sh80000000), 1'b1);
    issue(make_beat(ACT_REMOVE, '0), 1'b1);
    issue(make_beat(ACT_REMOVE, -32'sd1), 1'b1);
    issue(make_beat(ACT_REMOVE, '0), 1'b1);
    issue(make_beat(ACT_INSERT, '0), 1'b1);
    issue(make_beat(ACT_INSERT, -32'sd1), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sd1), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sd5), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sd5), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sd5), 1'b1);
    issue(make_beat(ACT_INSERT, -32'sd7), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sd3), 1'b1);
    repeat (8) issue(make_beat(ACT_REMOVE, '0), 1'b1);
    issue(make_beat(ACT_INSERT, 32'sh80000000), 1'b1);
    issue(make_beat(ACT_REMOVE, '0), 1'b1);

    // Random phases: fill to overflow, drain to underflow, or churn in between.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        kind = MIX_FILL;
      end else if (pick < 7) begin
        kind = MIX_DRAIN;
      end else begin
        kind = MIX_CHURN;
      end
      case (kind)
        MIX_FILL:  ins_pct = 85;
        MIX_DRAIN: ins_pct = 15;
        default:   ins_pct = 50;
      endcase
      extra = $urandom_range(1, 4);
      span  = $urandom_range(20, 120);
      steps = 0;
      while (sent < RAND_ITEMS) begin
        if (kind == MIX_FILL && drv_held == CAP) begin
          if (extra == 0) break;
          extra--;
        end else if (kind == MIX_DRAIN && drv_held == 0) begin
          if (extra == 0) break;
          extra--;
        end else if (kind == MIX_CHURN && steps == span) begin
          break;
        end
        act      = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
        // A long stretch in the middle runs back to back.
        may_idle = !(sent >= 600 && sent < 900);
        issue(make_beat(act, pick_value()), may_idle);
        steps++;
        sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Let the last replies arrive; the watchdog bounds this wait.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: %0d replies never arrived", $time, sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
